### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert that a implies b on the same edge
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// assert that a implies b on the next edge
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

### hw/rtl/sia_pkg.sv
// Package for the signed integer ALU: operation codes, states, widths.
// No dependencies.
`default_nettype none
package sia_pkg;
    localparam int DATA_WIDTH_DEF = 64;
    localparam int OP_W = 5;
    localparam int IO_W = 64;

    typedef enum logic [4:0] {
        OP_PLUS = 5'd0, OP_NEG = 5'd1, OP_NOT = 5'd2, OP_INC = 5'd3, OP_DEC = 5'd4,
        OP_ADD = 5'd5, OP_SUB = 5'd6, OP_MUL = 5'd7, OP_DIV = 5'd8, OP_MOD = 5'd9,
        OP_POW = 5'd10, OP_AND = 5'd11, OP_OR = 5'd12, OP_XOR = 5'd13,
        OP_SHL = 5'd14, OP_SAR = 5'd15, OP_LT = 5'd16, OP_GT = 5'd17,
        OP_LE = 5'd18, OP_GE = 5'd19, OP_EQ = 5'd20, OP_NE = 5'd21
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_DIV, ST_POW_MUL, ST_POW_SQR, ST_SHIFT, ST_DONE
    } state_t;

    // control from sequencer to shared unit
    typedef struct packed {
        logic load;     // first step of an iterative op
        logic step;     // one iteration
    } unit_ctl_t;
endpackage
`default_nettype wire

### hw/rtl/sia_mul_unit.sv
// Shared shift-add multiplier: one bit of the multiplier per cycle while step is high.
// Depends on sia_pkg.
`default_nettype none
module sia_mul_unit #(
    parameter int DATA_WIDTH = sia_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                  clk,
    input  wire sia_pkg::unit_ctl_t    ctl,
    input  wire logic [DATA_WIDTH-1:0] mcand,
    input  wire logic [DATA_WIDTH-1:0] mplier,
    output logic [DATA_WIDTH-1:0]      product,
    output logic                       busy
);
    localparam int CW = $clog2(DATA_WIDTH + 1);
    logic [DATA_WIDTH-1:0] acc_reg, mc_reg, mp_reg;
    logic [CW-1:0]         cnt_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            acc_reg <= '0;
            mc_reg  <= mcand;
            mp_reg  <= mplier;
            cnt_reg <= CW'(DATA_WIDTH);
        end
        else if (ctl.step && cnt_reg != '0)
        begin
            if (mp_reg[0])
                acc_reg <= acc_reg + mc_reg;
            mc_reg  <= mc_reg << 1;
            mp_reg  <= mp_reg >> 1;
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    // stop early when no multiplier bits remain
    assign busy    = (cnt_reg != '0) && (mp_reg != '0);
    assign product = acc_reg;
endmodule
`default_nettype wire

### hw/rtl/sia_div_unit.sv
// Radix-2 restoring divider on magnitudes, one quotient bit per cycle while step is high.
// Depends on sia_pkg.
`default_nettype none
module sia_div_unit #(
    parameter int DATA_WIDTH = sia_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                  clk,
    input  wire sia_pkg::unit_ctl_t    ctl,
    input  wire logic [DATA_WIDTH-1:0] dividend,
    input  wire logic [DATA_WIDTH-1:0] divisor,
    output logic [DATA_WIDTH-1:0]      quotient,
    output logic [DATA_WIDTH-1:0]      remainder,
    output logic                       busy
);
    localparam int CW = $clog2(DATA_WIDTH + 1);
    logic [DATA_WIDTH-1:0] q_reg, r_reg, d_reg;
    logic [CW-1:0]         cnt_reg;
    logic [DATA_WIDTH:0]   trial;

    assign trial = {r_reg, q_reg[DATA_WIDTH-1]} - {1'b0, d_reg};

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            q_reg   <= dividend;
            r_reg   <= '0;
            d_reg   <= divisor;
            cnt_reg <= CW'(DATA_WIDTH);
        end
        else if (ctl.step && cnt_reg != '0)
        begin
            if (!trial[DATA_WIDTH])
            begin
                r_reg <= trial[DATA_WIDTH-1:0];
                q_reg <= {q_reg[DATA_WIDTH-2:0], 1'b1};
            end
            else
            begin
                r_reg <= {r_reg[DATA_WIDTH-2:0], q_reg[DATA_WIDTH-1]};
                q_reg <= {q_reg[DATA_WIDTH-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    assign busy      = cnt_reg != '0;
    assign quotient  = q_reg;
    assign remainder = r_reg;
endmodule
`default_nettype wire

### hw/rtl/signed_integer_alu.sv
// Signed integer ALU top level: stream ports, sequencer, simple ops.
// Depends on sia_pkg, sia_mul_unit, sia_div_unit and assert_macros.svh.
//
// Usage: one item on s_axis (op + two operands) gives one item on m_axis
// (result + error flag). The block takes one item at a time: s_axis_tready
// is high only when no item is in work and the output register is empty.
// Paths from accept to m_axis_tvalid, each ending in ST_DONE:
//   logic, add, compare and bad-argument cases go straight to ST_DONE;
//   shift by n: one bit position per cycle in ST_SHIFT;
//   mul: runs the shift-add multiplier in ST_MUL;
//   div/mod: loads and runs the radix-2 divider loop;
//   power: square-and-multiply over the exponent bits, squares and
//   multiplies sharing the one multiplier.
// The result stays in its output register until m_axis_tready is high;
// a stalled receiver holds the block busy. Reset (rst_n low) empties the
// sequencer and the output register; no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"
module signed_integer_alu #(
    parameter int DATA_WIDTH = sia_pkg::DATA_WIDTH_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [4:0] operation, [68:5] left_operand, [132:69] right_operand, rest 0
    input  wire logic [135:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [63:0] result_value, [64] error_flag, rest 0
    output logic [71:0]       m_axis_tdata
);
    localparam int W  = DATA_WIDTH;
    localparam int SW = $clog2(W + 1);
    localparam int IO = sia_pkg::IO_W;

    sia_pkg::state_t state_reg, state_next;
    logic [sia_pkg::OP_W-1:0] op_reg;
    logic [W-1:0] a_reg, b_reg, base_reg, exp_reg, acc_reg, a_next, b_next;
    logic [W-1:0] base_next, exp_next, acc_next;
    logic [W-1:0] res_reg, res_next;
    logic         err_reg, err_next, neg_reg, neg_next;
    logic [SW-1:0] sh_reg, sh_next;
    logic         outv_reg, outv_next;

    sia_pkg::unit_ctl_t mctl, dctl;
    logic [W-1:0] m_a, m_b, m_p, d_q, d_r;
    logic         m_busy, d_busy;

    logic [W-1:0] in_a, in_b;
    logic [sia_pkg::OP_W-1:0] in_op;
    assign in_op = s_axis_tdata[4:0];
    assign in_a  = s_axis_tdata[5 +: W];
    assign in_b  = s_axis_tdata[69 +: W];

    sia_mul_unit #(.DATA_WIDTH(W)) u_mul (
        .clk(clk), .ctl(mctl), .mcand(m_a), .mplier(m_b),
        .product(m_p), .busy(m_busy)
    );
    sia_div_unit #(.DATA_WIDTH(W)) u_div (
        .clk(clk), .ctl(dctl), .dividend(a_reg), .divisor(b_reg),
        .quotient(d_q), .remainder(d_r), .busy(d_busy)
    );

    assign s_axis_tready = (state_reg == sia_pkg::ST_IDLE) && !outv_reg;

    logic signed [W-1:0] sa, sb;
    logic [W-1:0] wmin, wneg1;
    assign sa    = in_a;
    assign sb    = in_b;
    assign wmin  = {1'b1, {(W-1){1'b0}}};
    assign wneg1 = '1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sia_pkg::ST_IDLE;
            outv_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            outv_reg  <= outv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= (s_axis_tvalid && s_axis_tready) ? in_op : op_reg;
        a_reg    <= a_next;
        b_reg    <= b_next;
        base_reg <= base_next;
        exp_reg  <= exp_next;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
        err_reg  <= err_next;
        neg_reg  <= neg_next;
        sh_reg   <= sh_next;
    end

    always_comb
    begin
        state_next = state_reg;
        outv_next  = outv_reg;
        a_next = a_reg; b_next = b_reg; base_next = base_reg; exp_next = exp_reg;
        acc_next = acc_reg; res_next = res_reg; err_next = err_reg;
        neg_next = neg_reg; sh_next = sh_reg;
        mctl = '0; dctl = '0;
        m_a = base_reg; m_b = base_reg;
        if (outv_reg && m_axis_tready)
            outv_next = 1'b0;
        case (state_reg)
            sia_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    state_next = sia_pkg::ST_DONE;
                    a_next = in_a; b_next = in_b;
                    err_next = 1'b0;
                    res_next = '0;
                    case (in_op)
                        sia_pkg::OP_PLUS: res_next = in_b;
                        sia_pkg::OP_NEG:  res_next = -in_b;
                        sia_pkg::OP_NOT:  res_next = ~in_b;
                        sia_pkg::OP_INC:  res_next = in_b + W'(1);
                        sia_pkg::OP_DEC:  res_next = in_b - W'(1);
                        sia_pkg::OP_ADD:  res_next = in_a + in_b;
                        sia_pkg::OP_SUB:  res_next = in_a - in_b;
                        sia_pkg::OP_MUL:
                        begin
                            m_a = in_a; m_b = in_b; mctl.load = 1'b1;
                            state_next = sia_pkg::ST_MUL;
                        end
                        sia_pkg::OP_DIV, sia_pkg::OP_MOD:
                        begin
                            if (in_b == '0 || (in_a == wmin && in_b == wneg1))
                                err_next = 1'b1;
                            else
                            begin
                                a_next = in_a[W-1] ? -in_a : in_a;
                                b_next = in_b[W-1] ? -in_b : in_b;
                                neg_next = (in_op == sia_pkg::OP_DIV) ?
                                    (in_a[W-1] ^ in_b[W-1]) : in_a[W-1];
                                state_next = sia_pkg::ST_DIV;
                            end
                        end
                        sia_pkg::OP_POW:
                        begin
                            if (in_b[W-1])
                            begin
                                // negative exponent: only unit bases survive
                                if (in_a == W'(1))
                                    res_next = W'(1);
                                else if (in_a == wneg1)
                                    res_next = in_b[0] ? wneg1 : W'(1);
                                else if (in_a == '0)
                                    err_next = 1'b1;
                            end
                            else
                            begin
                                base_next = in_a; exp_next = in_b;
                                acc_next = W'(1);
                                state_next = sia_pkg::ST_POW_MUL;
                            end
                        end
                        sia_pkg::OP_AND:  res_next = in_a & in_b;
                        sia_pkg::OP_OR:   res_next = in_a | in_b;
                        sia_pkg::OP_XOR:  res_next = in_a ^ in_b;
                        sia_pkg::OP_SHL, sia_pkg::OP_SAR:
                        begin
                            if (in_b[W-1] || in_b >= W'(W))
                                err_next = 1'b1;
                            else
                            begin
                                res_next = in_a;
                                sh_next = SW'(in_b);
                                state_next = sia_pkg::ST_SHIFT;
                            end
                        end
                        sia_pkg::OP_LT:   res_next = W'(sa < sb);
                        sia_pkg::OP_GT:   res_next = W'(sa > sb);
                        sia_pkg::OP_LE:   res_next = W'(sa <= sb);
                        sia_pkg::OP_GE:   res_next = W'(sa >= sb);
                        sia_pkg::OP_EQ:   res_next = W'(in_a == in_b);
                        sia_pkg::OP_NE:   res_next = W'(in_a != in_b);
                        default:          err_next = 1'b1;
                    endcase
                end
            end
            sia_pkg::ST_MUL:
            begin
                mctl.step = 1'b1;
                if (!m_busy)
                begin
                    res_next = m_p;
                    state_next = sia_pkg::ST_DONE;
                end
            end
            sia_pkg::ST_DIV:
            begin
                dctl.load = 1'b1;
                state_next = sia_pkg::ST_POW_SQR;
                neg_next = neg_reg;
                // reuse ST_POW_SQR, then ST_POW_MUL guarded by op; see below
            end
            sia_pkg::ST_POW_MUL:
            begin
                if (op_reg != sia_pkg::OP_POW)
                begin
                    // divide loop running
                    dctl.step = 1'b1;
                    if (!d_busy)
                    begin
                        res_next = (op_reg == sia_pkg::OP_DIV) ? d_q : d_r;
                        if (neg_reg)
                            res_next = -res_next;
                        state_next = sia_pkg::ST_DONE;
                    end
                end
                else if (exp_reg == '0)
                begin
                    res_next = acc_reg;
                    state_next = sia_pkg::ST_DONE;
                end
                else if (exp_reg[0])
                begin
                    // acc *= base
                    m_a = acc_reg; m_b = base_reg; mctl.load = 1'b1;
                    neg_next = 1'b1;
                    state_next = sia_pkg::ST_SHIFT;
                end
                else
                begin
                    m_a = base_reg; m_b = base_reg; mctl.load = 1'b1;
                    neg_next = 1'b0;
                    state_next = sia_pkg::ST_SHIFT;
                end
            end
            sia_pkg::ST_POW_SQR:
            begin
                // divider loaded last cycle; step it here, then run loop in ST_POW_MUL
                state_next = sia_pkg::ST_POW_MUL;
                dctl.step = 1'b1;
            end
            sia_pkg::ST_SHIFT:
            begin
                if (op_reg == sia_pkg::OP_POW)
                begin
                    mctl.step = 1'b1;
                    if (!m_busy)
                    begin
                        if (neg_reg)
                        begin
                            acc_next = m_p;
                            exp_next = {exp_reg[W-1:1], 1'b0};
                        end
                        else
                        begin
                            base_next = m_p;
                            exp_next = exp_reg >> 1;
                        end
                        state_next = sia_pkg::ST_POW_MUL;
                    end
                end
                else if (sh_reg == '0)
                    state_next = sia_pkg::ST_DONE;
                else
                begin
                    res_next = (op_reg == sia_pkg::OP_SHL) ? (res_reg << 1) :
                        {res_reg[W-1], res_reg[W-1:1]};
                    sh_next = sh_reg - SW'(1);
                end
            end
            sia_pkg::ST_DONE:
            begin
                if (!outv_reg)
                begin
                    outv_next = 1'b1;
                    state_next = sia_pkg::ST_IDLE;
                    if (err_reg)
                        res_next = '0;
                end
            end
            default: state_next = sia_pkg::ST_IDLE;
        endcase
    end

    logic [IO-1:0] res_ext;
    assign res_ext = IO'(signed'(res_reg));
    assign m_axis_tvalid = outv_reg;
    assign m_axis_tdata  = {7'd0, err_reg, res_ext};

    `ASSERT_IMPL(a_ready_idle, clk, rst_n, s_axis_tready,
        state_reg == sia_pkg::ST_IDLE && !m_axis_tvalid)
    `ASSERT_NEXT(a_acc_busy, clk, rst_n, s_axis_tvalid && s_axis_tready,
        !s_axis_tready)
    `ASSERT_IMPL(a_err_zero, clk, rst_n, m_axis_tvalid && m_axis_tdata[64],
        m_axis_tdata[63:0] == 64'd0)
endmodule
`default_nettype wire
